[rtl/trle_pkg.sv]
package trle_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_HEIGHT_DEF = 1024;

	localparam logic [10:0] WIDTH_RST  = 11'd32;
	localparam logic [10:0] HEIGHT_RST = 11'd32;

	localparam int unsigned CFG_W   = 11;
	localparam int unsigned QDEPTH  = 4;
	localparam logic [7:0]  LIT_MAX = 8'h7F;

	typedef enum logic {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		WK_NONE   = 2'd0,
		WK_OPAQUE = 2'd1,
		WK_SKIP   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_CROSS = 2'd1,
		ST_TRUNC = 2'd2,
		ST_ROWS  = 2'd3
	} status_t;

	// classified code byte as it travels from front to back
	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       opaque;
		logic [7:0] run;
	} item_t;

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [12:0] eff_dim(input logic [10:0] v, input int unsigned maxv);
		logic [12:0] r;
		if (v == 11'd0) begin
			r = 13'd1;
		end else if (32'(v) > maxv) begin
			r = 13'(maxv);
		end else begin
			r = 13'(v);
		end
		return r;
	endfunction

endpackage

[rtl/trle_front.sv]
module trle_front #(
	parameter int unsigned MAX_WIDTH  = trle_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = trle_pkg::MAX_HEIGHT_DEF,
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
	localparam int unsigned RH = $clog2(MAX_HEIGHT)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [trle_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    code_byte,
	input  logic                          last_byte,
	input  logic                          q_full,
	output logic                          q_push,
	output trle_pkg::item_t               q_item,
	output logic [WW-1:0]                 w_eff,
	output logic [RH-1:0]                 rows_top,
	output logic                          restart
);
	import trle_pkg::*;

	logic [WW-1:0] w_q;
	logic [RH-1:0] rows_top_q;
	logic [RH-1:0] rows_new;

	assign rows_new = RH'(eff_dim(cfg_data, MAX_HEIGHT) - 13'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= WW'(eff_dim(WIDTH_RST, MAX_WIDTH));
			rows_top_q <= RH'(eff_dim(HEIGHT_RST, MAX_HEIGHT) - 13'd1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  w_q        <= WW'(eff_dim(cfg_data, MAX_WIDTH));
				CFG_HEIGHT: rows_top_q <= rows_new;
				default:    w_q        <= w_q;
			endcase
		end
	end

	assign w_eff    = w_q;
	// a height write reaches the restart in the same cycle
	assign rows_top = (cfg_we && cfg_index == CFG_HEIGHT) ? rows_new : rows_top_q;
	// any register write starts the frame over
	assign restart  = cfg_we;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item.code   = code_byte;
		q_item.last   = last_byte;
		q_item.opaque = (code_byte <= LIT_MAX);
		// skip length is 256 minus the code
		q_item.run    = q_item.opaque ? code_byte : 8'(9'h100 - 9'(code_byte));
	end

endmodule

[rtl/trle_queue.sv]
module trle_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  trle_pkg::item_t din,
	output logic            full,
	input  logic            pop,
	output trle_pkg::item_t dout,
	output logic            nonempty
);
	import trle_pkg::*;

	localparam int unsigned PW = $clog2(QDEPTH);
	localparam int unsigned CW = $clog2(QDEPTH + 1);

	item_t         mem_q [QDEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign dout     = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH))
		else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

endmodule

[rtl/trle_back.sv]
module trle_back #(
	parameter int unsigned MAX_WIDTH  = trle_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = trle_pkg::MAX_HEIGHT_DEF,
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
	localparam int unsigned RH = $clog2(MAX_HEIGHT)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nonempty,
	input  trle_pkg::item_t q_item,
	output logic            q_pop,
	input  logic            restart,
	input  logic [WW-1:0]   w_eff,
	input  logic [RH-1:0]   rows_top,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      write_kind,
	output logic [9:0]      column,
	output logic [9:0]      row,
	output logic [7:0]      run_length,
	output logic [7:0]      pixel_index,
	output logic            frame_done,
	output logic [1:0]      frame_status
);
	import trle_pkg::*;

	localparam int unsigned SW = ((WW > 8) ? WW : 8) + 1;

	logic [WW-1:0] col_q, col_d;
	logic [RH-1:0] rows_q, rows_d;
	logic [6:0]    lit_q, lit_d;
	logic          fin_q, fin_d;
	status_t       err_q, err_d;
	logic          chk;
	logic [SW-1:0] run_end;
	logic [6:0]    lit_m1;

	kind_t         kind_o;
	logic [9:0]    col_o, row_o;
	logic [7:0]    len_o, pix_o;

	logic          out_valid_q;
	kind_t         kind_q;
	logic [9:0]    col_out_q, row_out_q;
	logic [7:0]    len_q, pix_q;
	logic          done_q;
	status_t       status_q;

	// take the next item whenever the output register frees up this cycle
	assign q_pop = q_nonempty && (!out_valid_q || !out_stall);

	assign run_end = SW'(col_q) + SW'(q_item.run);
	assign lit_m1  = lit_q - 7'd1;

	always_comb begin
		col_d  = col_q;
		rows_d = rows_q;
		lit_d  = lit_q;
		fin_d  = fin_q;
		err_d  = err_q;
		chk    = 1'b0;
		kind_o = WK_NONE;
		col_o  = '0;
		row_o  = '0;
		len_o  = '0;
		pix_o  = '0;
		if (!fin_q) begin
			if (lit_q != '0) begin
				kind_o = WK_OPAQUE;
				col_o  = 10'(col_q);
				row_o  = 10'(rows_q);
				len_o  = 8'd1;
				pix_o  = q_item.code;
				col_d  = col_q + 1'b1;
				lit_d  = lit_m1;
				if (lit_m1 != '0) begin
					if (q_item.last) begin
						err_d = ST_TRUNC;
						fin_d = 1'b1;
					end
				end else begin
					chk = 1'b1;
				end
			end else if (run_end > SW'(w_eff)) begin
				err_d = ST_CROSS;
				fin_d = 1'b1;
			end else if (q_item.opaque) begin
				if (q_item.run != '0) begin
					if (q_item.last) begin
						err_d = ST_TRUNC;
						fin_d = 1'b1;
					end else begin
						lit_d = q_item.run[6:0];
					end
				end
			end else begin
				kind_o = WK_SKIP;
				col_o  = 10'(col_q);
				row_o  = 10'(rows_q);
				len_o  = q_item.run;
				col_d  = WW'(run_end);
				chk    = 1'b1;
			end
		end
		// row full: wrap and move one row up, or finish the frame on the last row
		if (chk && col_d >= w_eff) begin
			col_d = '0;
			if (rows_q == '0) begin
				fin_d = 1'b1;
			end else begin
				rows_d = rows_q - 1'b1;
			end
		end
		if (q_item.last && !fin_d && err_d == ST_OK) begin
			err_d = ST_ROWS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			rows_q <= RH'(eff_dim(HEIGHT_RST, MAX_HEIGHT) - 13'd1);
			lit_q  <= '0;
			fin_q  <= 1'b0;
			err_q  <= ST_OK;
		end else if (restart || (q_pop && q_item.last)) begin
			col_q  <= '0;
			rows_q <= rows_top;
			lit_q  <= '0;
			fin_q  <= 1'b0;
			err_q  <= ST_OK;
		end else if (q_pop) begin
			col_q  <= col_d;
			rows_q <= rows_d;
			lit_q  <= lit_d;
			fin_q  <= fin_d;
			err_q  <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q    <= kind_o;
			col_out_q <= col_o;
			row_out_q <= row_o;
			len_q     <= len_o;
			pix_q     <= pix_o;
			done_q    <= q_item.last;
			status_q  <= err_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign write_kind   = kind_q;
	assign column       = col_out_q;
	assign row          = row_out_q;
	assign run_length   = len_q;
	assign pixel_index  = pix_q;
	assign frame_done   = done_q;
	assign frame_status = status_q;

	a_lit_open: assert property (@(posedge clk) disable iff (!arst_n)
		lit_q != '0 |-> !fin_q)
		else $error("literal run pending in a finished frame");
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_eff)
		else $error("column position past row end");
	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_kind == WK_NONE |->
			column == '0 && row == '0 && run_length == '0 && pixel_index == '0)
		else $error("empty result carries payload");
	a_skip_no_pix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_kind == WK_SKIP |-> pixel_index == '0 && run_length != '0)
		else $error("skip result malformed");

endmodule

[rtl/transparent_rle_frame_decoder_unit.sv]
// channel   direction  handshake              payload
// in        input      in_valid / in_stall     code_byte, last_byte
// out       output     out_valid / out_stall   write_kind, column, row, run_length,
//                                              pixel_index, frame_done, frame_status
// cfg       input      cfg_we                  cfg_index, cfg_data
//
// One code byte per cycle while out_stall is low; each item gives exactly one result.
// From input accept to result, an item passes through the four-entry queue and then
// through the decode state update into the output register.
// The input stalls only when the queue is full; the back end stalls only on out_stall.
// Reset clears the decode state and loads width and height 32; no clearing pass.
module transparent_rle_frame_decoder_unit #(
	parameter int unsigned MAX_WIDTH  = trle_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = trle_pkg::MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [trle_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 code_byte,
	input  logic                       last_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 write_kind,
	output logic [9:0]                 column,
	output logic [9:0]                 row,
	output logic [7:0]                 run_length,
	output logic [7:0]                 pixel_index,
	output logic                       frame_done,
	output logic [1:0]                 frame_status
);
	import trle_pkg::*;

	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RH = $clog2(MAX_HEIGHT);

	item_t         push_item;
	item_t         pop_item;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_nonempty;
	logic [WW-1:0] w_eff;
	logic [RH-1:0] rows_top;
	logic          restart;

	trle_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.code_byte (code_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item),
		.w_eff     (w_eff),
		.rows_top  (rows_top),
		.restart   (restart)
	);

	trle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.din      (push_item),
		.full     (q_full),
		.pop      (q_pop),
		.dout     (pop_item),
		.nonempty (q_nonempty)
	);

	trle_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_item       (pop_item),
		.q_pop        (q_pop),
		.restart      (restart),
		.w_eff        (w_eff),
		.rows_top     (rows_top),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.write_kind   (write_kind),
		.column       (column),
		.row          (row),
		.run_length   (run_length),
		.pixel_index  (pixel_index),
		.frame_done   (frame_done),
		.frame_status (frame_status)
	);

endmodule
